@@ sv/hgdt_pkg.sv @@
// ----------------------------------------------------------------------------
// hgdt_pkg
// Shared widths, character codes, transfer structs and conversion helpers
// for the hex-group to decimal text converter.
// ----------------------------------------------------------------------------
package hgdt_pkg;

  // field and datapath widths
  localparam int CHAR_W    = 8;
  localparam int NIB_W     = 4;
  localparam int ACC_W     = 12;
  localparam int CNT_W     = 2;
  localparam int VALUE_W   = 16;
  localparam int BCD_DIGITS = 5;
  localparam int BCD_W     = BCD_DIGITS * NIB_W;
  localparam int SCR_W     = BCD_W + VALUE_W;
  localparam int ND_W      = 3;

  // double-dabble shift steps done in each of the two stages
  localparam int DD_STEPS_PER_STAGE = VALUE_W / 2;

  // default group size
  localparam int HEX_DIGITS_PER_GROUP_DEF = 4;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE     = 8'd57;
  localparam logic [CHAR_W-1:0] CHAR_A_OFFSET = 8'd55;
  localparam logic [CHAR_W-1:0] CHAR_COMMA    = 8'd44;

  // completed group on its way to the converter
  typedef struct packed {
    logic               vld;
    logic [VALUE_W-1:0] value;
  } grp_xfer_t;

  // converted digits on their way to the emitter
  typedef struct packed {
    logic             vld;
    logic [BCD_W-1:0] digits;
  } bcd_xfer_t;

  // ascii hex character to nibble, non-digits map to (code - 55) mod 16
  function automatic logic [NIB_W-1:0] char_to_nibble(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] diff;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      diff = c - CHAR_ZERO;
    end else begin
      diff = c - CHAR_A_OFFSET;
    end
    return diff[NIB_W-1:0];
  endfunction

  // one double-dabble step: correct each bcd digit, then shift left
  function automatic logic [SCR_W-1:0] dd_step(input logic [SCR_W-1:0] s);
    logic [SCR_W-1:0] t;
    t = s;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (t[VALUE_W + NIB_W*d +: NIB_W] >= 4'd5) begin
        t[VALUE_W + NIB_W*d +: NIB_W] = t[VALUE_W + NIB_W*d +: NIB_W] + 4'd3;
      end
    end
    return {t[SCR_W-2:0], 1'b0};
  endfunction

endpackage

@@ sv/hgdt_accum.sv @@
// ----------------------------------------------------------------------------
// hgdt_accum
// Collects hex characters into nibble groups and registers each completed
// 16-bit group value for the converter.
// ----------------------------------------------------------------------------
module hgdt_accum #(
  parameter int HEX_DIGITS_PER_GROUP = hgdt_pkg::HEX_DIGITS_PER_GROUP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hgdt_pkg::CHAR_W-1:0] in_hex_char,
  output hgdt_pkg::grp_xfer_t         grp_o,
  input  logic                        grp_ready
);

  localparam logic [hgdt_pkg::CNT_W:0] GROUP_LEN = (hgdt_pkg::CNT_W+1)'(HEX_DIGITS_PER_GROUP);

  logic [hgdt_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [hgdt_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         grp_vld_r, grp_vld_nxt;
  logic [hgdt_pkg::VALUE_W-1:0] grp_value_r, grp_value_nxt;
  logic [hgdt_pkg::NIB_W-1:0]   nib;
  logic [hgdt_pkg::CNT_W:0]     cnt_inc;
  logic                         in_xfer;

  assign in_ready = !grp_vld_r || grp_ready;
  assign in_xfer  = in_valid && in_ready;
  assign nib      = hgdt_pkg::char_to_nibble(in_hex_char);
  assign cnt_inc  = {1'b0, cnt_r} + 1'b1;

  // nibble collection and group completion
  always_comb begin
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    grp_value_nxt = grp_value_r;
    grp_vld_nxt   = grp_vld_r && !grp_ready;
    if (in_xfer) begin
      if (cnt_inc < GROUP_LEN) begin
        acc_nxt = {acc_r[hgdt_pkg::ACC_W-hgdt_pkg::NIB_W-1:0], nib};
        cnt_nxt = cnt_inc[hgdt_pkg::CNT_W-1:0];
      end else begin
        grp_value_nxt = {acc_r, nib};
        grp_vld_nxt   = 1'b1;
        acc_nxt       = '0;
        cnt_nxt       = '0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      cnt_r     <= '0;
      grp_vld_r <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      cnt_r     <= cnt_nxt;
      grp_vld_r <= grp_vld_nxt;
    end
  end

  // group value register
  always_ff @(posedge clk) begin
    grp_value_r <= grp_value_nxt;
  end

  assign grp_o.vld   = grp_vld_r;
  assign grp_o.value = grp_value_r;

  // count never reaches the group length
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_inc <= GROUP_LEN)
    else $error("nibble count beyond group length");

endmodule

@@ sv/hgdt_bcd.sv @@
// ----------------------------------------------------------------------------
// hgdt_bcd
// Two-stage double-dabble converter from a 16-bit value to five bcd digits,
// eight shift steps per stage, stallable.
// ----------------------------------------------------------------------------
module hgdt_bcd (
  input  logic                clk,
  input  logic                rst_n,
  input  hgdt_pkg::grp_xfer_t grp_i,
  output logic                grp_ready,
  output hgdt_pkg::bcd_xfer_t bcd_o,
  input  logic                bcd_ready
);

  logic                       s1_vld_r, s1_vld_nxt;
  logic                       s2_vld_r, s2_vld_nxt;
  logic [hgdt_pkg::SCR_W-1:0] s1_r, s1_nxt;
  logic [hgdt_pkg::SCR_W-1:0] s2_r, s2_nxt;
  logic                       s1_ready, s2_ready;

  assign s2_ready  = !s2_vld_r || bcd_ready;
  assign s1_ready  = !s1_vld_r || s2_ready;
  assign grp_ready = s1_ready;

  // first half of the shift steps
  always_comb begin
    s1_nxt = {{hgdt_pkg::BCD_W{1'b0}}, grp_i.value};
    for (int i = 0; i < hgdt_pkg::DD_STEPS_PER_STAGE; i++) begin
      s1_nxt = hgdt_pkg::dd_step(s1_nxt);
    end
  end

  // second half of the shift steps
  always_comb begin
    s2_nxt = s1_r;
    for (int i = 0; i < hgdt_pkg::DD_STEPS_PER_STAGE; i++) begin
      s2_nxt = hgdt_pkg::dd_step(s2_nxt);
    end
  end

  // stage valid flags
  always_comb begin
    s1_vld_nxt = s1_ready ? grp_i.vld : s1_vld_r;
    s2_vld_nxt = s2_ready ? s1_vld_r : s2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_r <= s1_nxt;
    end
    if (s2_ready) begin
      s2_r <= s2_nxt;
    end
  end

  assign bcd_o.vld    = s2_vld_r;
  assign bcd_o.digits = s2_r[hgdt_pkg::SCR_W-1 -: hgdt_pkg::BCD_W];

  // every finished digit is a decimal digit
  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> (s2_r[32 +: 4] <= 4'd9 && s2_r[28 +: 4] <= 4'd9 &&
                  s2_r[24 +: 4] <= 4'd9 && s2_r[20 +: 4] <= 4'd9 &&
                  s2_r[16 +: 4] <= 4'd9))
    else $error("bcd digit out of range");

endmodule

@@ sv/hgdt_emit.sv @@
// ----------------------------------------------------------------------------
// hgdt_emit
// Drops leading zeros and sends the digits, then a comma marked last, one
// character per transfer from the output register.
// ----------------------------------------------------------------------------
module hgdt_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hgdt_pkg::bcd_xfer_t         bcd_i,
  output logic                        bcd_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hgdt_pkg::CHAR_W-1:0] out_char,
  output logic                        out_last_of_run
);

  localparam int NIB_W = hgdt_pkg::NIB_W;
  localparam int BCD_W = hgdt_pkg::BCD_W;
  localparam int ND_W  = hgdt_pkg::ND_W;

  logic                        vld_r, vld_nxt;
  logic                        last_r, last_nxt;
  logic [hgdt_pkg::CHAR_W-1:0] char_r, char_nxt;
  logic [BCD_W-1:0]            rest_r, rest_nxt;
  logic [ND_W-1:0]             left_r, left_nxt;
  logic [ND_W-1:0]             nd;
  logic [4:0]                  sh;
  logic [BCD_W-1:0]            aligned;
  logic                        load;

  assign bcd_ready = !vld_r || (out_ready && last_r);
  assign load      = bcd_i.vld && bcd_ready;

  // count of significant digits, at least one
  always_comb begin
    nd = ND_W'(1);
    for (int d = 1; d < hgdt_pkg::BCD_DIGITS; d++) begin
      if (bcd_i.digits[NIB_W*d +: NIB_W] != '0) begin
        nd = ND_W'(d + 1);
      end
    end
    sh      = 5'(NIB_W * (hgdt_pkg::BCD_DIGITS - int'(nd)));
    aligned = bcd_i.digits << sh;
  end

  // character sequencing
  always_comb begin
    vld_nxt  = vld_r;
    last_nxt = last_r;
    char_nxt = char_r;
    rest_nxt = rest_r;
    left_nxt = left_r;
    if (load) begin
      vld_nxt  = 1'b1;
      last_nxt = 1'b0;
      char_nxt = hgdt_pkg::CHAR_ZERO + {4'b0, aligned[BCD_W-1 -: NIB_W]};
      rest_nxt = {aligned[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
      left_nxt = nd - 1'b1;
    end else if (vld_r && out_ready) begin
      if (last_r) begin
        vld_nxt = 1'b0;
      end else if (left_r != '0) begin
        char_nxt = hgdt_pkg::CHAR_ZERO + {4'b0, rest_r[BCD_W-1 -: NIB_W]};
        rest_nxt = {rest_r[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
        left_nxt = left_r - 1'b1;
      end else begin
        char_nxt = hgdt_pkg::CHAR_COMMA;
        last_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      last_r <= 1'b0;
      left_r <= '0;
    end else begin
      vld_r  <= vld_nxt;
      last_r <= last_nxt;
      left_r <= left_nxt;
    end
  end

  // output payload registers
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    rest_r <= rest_nxt;
  end

  assign out_valid       = vld_r;
  assign out_char        = char_r;
  assign out_last_of_run = last_r;

  // a digit transfer carries an ascii digit
  a_digit_char: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !last_r) |-> (char_r >= hgdt_pkg::CHAR_ZERO && char_r <= hgdt_pkg::CHAR_NINE))
    else $error("digit transfer is not a decimal digit");

  // the last transfer of a run is the comma
  a_last_comma: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && last_r) |-> (char_r == hgdt_pkg::CHAR_COMMA))
    else $error("last transfer is not a comma");

  // no digits are pending once the comma is up
  a_comma_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && last_r) |-> (left_r == '0))
    else $error("comma sent with digits pending");

endmodule

@@ sv/hex_group_to_decimal_text.sv @@
// A group's value passes the group register, both converter stages and
// the output character register before its first output character is
// valid; digits then follow one per cycle while out_ready is high. One
// input character per cycle while in_ready is high; the next group is
// collected while earlier ones are sent. Synchronous active-low reset
// clears the nibble state and all valid flags.
// ----------------------------------------------------------------------------
// hex_group_to_decimal_text
// Turns groups of ascii hex characters into comma-terminated decimal text.
// ----------------------------------------------------------------------------
module hex_group_to_decimal_text #(
  parameter int HEX_DIGITS_PER_GROUP = hgdt_pkg::HEX_DIGITS_PER_GROUP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hgdt_pkg::CHAR_W-1:0] in_hex_char,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hgdt_pkg::CHAR_W-1:0] out_char,
  output logic                        out_last_of_run
);

  hgdt_pkg::grp_xfer_t grp;
  hgdt_pkg::bcd_xfer_t bcd;
  logic                grp_ready;
  logic                bcd_ready;

  // nibble collection
  hgdt_accum #(
    .HEX_DIGITS_PER_GROUP(HEX_DIGITS_PER_GROUP)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_hex_char (in_hex_char),
    .grp_o       (grp),
    .grp_ready   (grp_ready)
  );

  // binary to bcd
  hgdt_bcd u_bcd (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_i     (grp),
    .grp_ready (grp_ready),
    .bcd_o     (bcd),
    .bcd_ready (bcd_ready)
  );

  // text emission
  hgdt_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .bcd_i           (bcd),
    .bcd_ready       (bcd_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run)
  );

endmodule
